>>> hdl/multisymbol_pbwt_column_update_unit_defines.svh
// Assertion macros shared by the column update unit.
// Each macro expects clk and rst_n in scope.
`ifndef MULTISYMBOL_PBWT_COLUMN_UPDATE_UNIT_DEFINES_SVH
`define MULTISYMBOL_PBWT_COLUMN_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication
`define PBCU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbcu check failed");

// Next-cycle implication
`define PBCU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbcu check failed");

`endif

>>> hdl/pbcu_pkg.sv
package pbcu_pkg;

  // Sizing
  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_HAPS    = 65536;
  localparam int COLUMN_BITS = 20;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int COL_W    = 20;
  localparam int SYM_W    = 5;
  localparam int CNT_W    = 17;
  localparam int HAP_W    = 16;
  localparam int DIV_W    = 20;

  // Derived internal widths
  localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);
  localparam int SYM_CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int SYM_M_W   = (SYM_CNT_W > SYM_W) ? SYM_CNT_W : SYM_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration space
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] CFG_MIN_COUNT = '0;
  localparam logic [CNT_W-1:0] MIN_COUNT_RESET = 17'd100;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_ROW   = 2'd2
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [COL_W-1:0] column;
    logic [SYM_W-1:0] symbol_total;
    logic [SYM_W-1:0] symbol;
    logic [CNT_W-1:0] sym_count;
    logic [HAP_W-1:0] hap_id;
    logic [COL_W-1:0] row_div;
  } pbcu_item_t;

  typedef struct packed {
    logic [HAP_W-1:0] dest_index;
    logic [HAP_W-1:0] hap_id;
    logic [DIV_W-1:0] divergence;
    logic [CNT_W-1:0] symbol_rank;
    logic [CNT_W-1:0] row_number;
    logic             is_common;
    logic             bad;
  } pbcu_result_t;

endpackage

>>> hdl/pbcu_cfg_regs.sv
module pbcu_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pbcu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pbcu_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pbcu_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [pbcu_pkg::CNT_W-1:0]        min_count
);

  logic [pbcu_pkg::CNT_W-1:0]        min_count_r;
  logic [pbcu_pkg::CNT_W-1:0]        min_count_nxt;
  logic [pbcu_pkg::CFG_ADDR_W-3:0]   reg_idx;
  logic                              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pbcu_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write decode
  always_comb begin
    min_count_nxt = min_count_r;
    if (wr_en && (reg_idx == pbcu_pkg::CFG_MIN_COUNT)) begin
      min_count_nxt = pwdata[pbcu_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_count_r <= pbcu_pkg::MIN_COUNT_RESET;
    end else begin
      min_count_r <= min_count_nxt;
    end
  end

  // Read back; unmapped words read zero
  always_comb begin
    prdata = '0;
    if (reg_idx == pbcu_pkg::CFG_MIN_COUNT) begin
      prdata = pbcu_pkg::CFG_DATA_W'(min_count_r);
    end
  end

  assign min_count = min_count_r;

endmodule

>>> hdl/pbcu_in_stage.sv
module pbcu_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pbcu_pkg::pbcu_item_t in_item,
  input  logic                 take,
  output logic                 s1_valid,
  output pbcu_pkg::pbcu_item_t s1_item
);

  logic                 valid_r;
  logic                 valid_nxt;
  pbcu_pkg::pbcu_item_t item_r;
  logic                 load;

  // Stage frees up in the same cycle its beat moves on
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> hdl/pbcu_core.sv
module pbcu_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pbcu_pkg::pbcu_item_t         item,
  input  logic                         take,
  input  logic [pbcu_pkg::CNT_W-1:0]   min_count,
  output logic                         has_result,
  output pbcu_pkg::pbcu_result_t       result
);

  localparam int NS = pbcu_pkg::MAX_SYMBOLS;
  localparam int CW = pbcu_pkg::CNT_W;
  localparam int DW = pbcu_pkg::COLUMN_BITS;

  // Per-symbol tables, one register per entry
  logic [DW-1:0] pend_r  [NS];
  logic [DW-1:0] pend_nxt[NS];
  logic [CW-1:0] fill_r  [NS];
  logic [CW-1:0] fill_nxt[NS];
  logic [CW-1:0] start_r [NS];
  logic [CW-1:0] start_nxt[NS];
  logic [CW-1:0] size_r  [NS];
  logic [CW-1:0] size_nxt[NS];

  logic [CW-1:0]                   offset_r, offset_nxt;
  logic [CW-1:0]                   prev_r, prev_nxt;
  logic [pbcu_pkg::SYM_CNT_W-1:0]  climit_r, climit_nxt;
  logic [pbcu_pkg::SYM_CNT_W-1:0]  siu_r, siu_nxt;
  logic [CW-1:0]                   rowcnt_r, rowcnt_nxt;

  logic [pbcu_pkg::SYM_M_W-1:0]    sym_m;
  logic                            sym_ok;
  logic [pbcu_pkg::SYM_IDX_W-1:0]  idx;
  logic [pbcu_pkg::SYM_M_W-1:0]    tot_m;
  logic [DW-1:0]                   col_v;
  logic [DW-1:0]                   ms_v;
  logic [DW-1:0]                   raised[NS];
  logic [CW-1:0]                   sel_fill, sel_start, sel_size;
  logic [CW:0]                     dest_sum;
  logic [CW:0]                     off_sum;
  logic                            row_bad;
  logic                            cnt_common;
  logic [CW-1:0]                   rowcnt_inc;

  // Symbol mapping: zero stands for the last symbol in use
  always_comb begin
    sym_m = (item.symbol == '0) ? pbcu_pkg::SYM_M_W'(siu_r)
                                : pbcu_pkg::SYM_M_W'(item.symbol);
    sym_ok = (sym_m != '0) && (sym_m <= pbcu_pkg::SYM_M_W'(siu_r)) &&
             (sym_m <= pbcu_pkg::SYM_M_W'(NS));
    idx = pbcu_pkg::SYM_IDX_W'(sym_m - pbcu_pkg::SYM_M_W'(1));
  end

  // Symbol total clamped into one..MAX_SYMBOLS
  always_comb begin
    tot_m = pbcu_pkg::SYM_M_W'(item.symbol_total);
    if (tot_m == '0) begin
      tot_m = pbcu_pkg::SYM_M_W'(1);
    end else if (tot_m > pbcu_pkg::SYM_M_W'(NS)) begin
      tot_m = pbcu_pkg::SYM_M_W'(NS);
    end
  end

  assign col_v = DW'(item.column);
  assign ms_v  = DW'(item.row_div);

  // Selected entry and bucket checks
  assign sel_fill  = fill_r[idx];
  assign sel_start = start_r[idx];
  assign sel_size  = size_r[idx];
  assign dest_sum  = {1'b0, sel_start} + {1'b0, sel_fill};
  assign row_bad   = !sym_ok || (sel_fill >= sel_size) ||
                     (32'(dest_sum) >= 32'(pbcu_pkg::MAX_HAPS));

  // Running max across all symbols, one comparator each
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      raised[i] = (ms_v > pend_r[i]) ? ms_v : pend_r[i];
    end
  end

  // Prefix sum and common test
  assign off_sum    = {1'b0, offset_r} + {1'b0, item.sym_count};
  assign cnt_common = (item.sym_count > min_count) &&
                      (item.sym_count <= prev_r) &&
                      (climit_r < pbcu_pkg::SYM_CNT_W'(NS));
  assign rowcnt_inc = (rowcnt_r < pbcu_pkg::CNT_MAX) ? rowcnt_r + CW'(1) : rowcnt_r;

  // Result beat for a row item
  always_comb begin
    has_result        = (item.req_type == pbcu_pkg::REQ_ROW);
    result.hap_id     = item.hap_id;
    result.row_number = rowcnt_inc;
    if (row_bad) begin
      result.dest_index  = '0;
      result.divergence  = '0;
      result.symbol_rank = '0;
      result.is_common   = 1'b0;
      result.bad         = 1'b1;
    end else begin
      result.dest_index  = pbcu_pkg::HAP_W'(dest_sum);
      result.divergence  = pbcu_pkg::DIV_W'(raised[idx]);
      result.symbol_rank = sel_fill + CW'(1);
      result.is_common   = (pbcu_pkg::SYM_M_W'(idx) < pbcu_pkg::SYM_M_W'(climit_r));
      result.bad         = 1'b0;
    end
  end

  // State update
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      pend_nxt[i]  = pend_r[i];
      fill_nxt[i]  = fill_r[i];
      start_nxt[i] = start_r[i];
      size_nxt[i]  = size_r[i];
    end
    offset_nxt = offset_r;
    prev_nxt   = prev_r;
    climit_nxt = climit_r;
    siu_nxt    = siu_r;
    rowcnt_nxt = rowcnt_r;
    if (take) begin
      unique case (item.req_type)
        pbcu_pkg::REQ_BEGIN: begin
          for (int i = 0; i < NS; i++) begin
            pend_nxt[i]  = col_v;
            fill_nxt[i]  = '0;
            start_nxt[i] = '0;
            size_nxt[i]  = '0;
          end
          offset_nxt = '0;
          prev_nxt   = pbcu_pkg::CNT_MAX;
          climit_nxt = '0;
          rowcnt_nxt = '0;
          siu_nxt    = pbcu_pkg::SYM_CNT_W'(tot_m);
        end
        pbcu_pkg::REQ_COUNT: begin
          if (sym_ok) begin
            start_nxt[idx] = offset_r;
            size_nxt[idx]  = item.sym_count;
            offset_nxt = off_sum[CW] ? pbcu_pkg::CNT_MAX : off_sum[CW-1:0];
            if (cnt_common) begin
              climit_nxt = climit_r + pbcu_pkg::SYM_CNT_W'(1);
            end
            prev_nxt = item.sym_count;
          end
        end
        pbcu_pkg::REQ_ROW: begin
          rowcnt_nxt = rowcnt_inc;
          if (!row_bad) begin
            for (int i = 0; i < NS; i++) begin
              pend_nxt[i] = raised[i];
            end
            pend_nxt[idx] = '0;
            fill_nxt[idx] = sel_fill + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        pend_r[i]  <= '0;
        fill_r[i]  <= '0;
        start_r[i] <= '0;
        size_r[i]  <= '0;
      end
      offset_r <= '0;
      prev_r   <= '0;
      climit_r <= '0;
      siu_r    <= pbcu_pkg::SYM_CNT_W'(1);
      rowcnt_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        pend_r[i]  <= pend_nxt[i];
        fill_r[i]  <= fill_nxt[i];
        start_r[i] <= start_nxt[i];
        size_r[i]  <= size_nxt[i];
      end
      offset_r <= offset_nxt;
      prev_r   <= prev_nxt;
      climit_r <= climit_nxt;
      siu_r    <= siu_nxt;
      rowcnt_r <= rowcnt_nxt;
    end
  end

endmodule

>>> hdl/pbcu_out_stage.sv
module pbcu_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  pbcu_pkg::pbcu_result_t res_in,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pbcu_pkg::pbcu_result_t res_out
);

  logic                   valid_r;
  logic                   valid_nxt;
  pbcu_pkg::pbcu_result_t res_r;

  // Room when empty or when the held beat leaves this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

>>> hdl/multisymbol_pbwt_column_update_unit.sv
// An accepted beat is held in the input register; the core takes it and
// loads its result into the output register, stalling while that is full.
// Throughput: one beat per cycle while row beats find room in the output stage;
// the per-symbol tables update with 16 parallel max comparators and one bucket add.
// Reset (rst_n low, synchronous): tables and counters cleared, one symbol in
// use, common threshold back to 100, both stages empty.
`include "multisymbol_pbwt_column_update_unit_defines.svh"

module multisymbol_pbwt_column_update_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pbcu_pkg::REQ_W-1:0]       in_req_type,
  input  logic [pbcu_pkg::COL_W-1:0]       in_column,
  input  logic [pbcu_pkg::SYM_W-1:0]       in_symbol_total,
  input  logic [pbcu_pkg::SYM_W-1:0]       in_symbol,
  input  logic [pbcu_pkg::CNT_W-1:0]       in_sym_count,
  input  logic [pbcu_pkg::HAP_W-1:0]       in_hap_id,
  input  logic [pbcu_pkg::COL_W-1:0]       in_row_div,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pbcu_pkg::HAP_W-1:0]       out_dest_index,
  output logic [pbcu_pkg::HAP_W-1:0]       out_hap_id,
  output logic [pbcu_pkg::DIV_W-1:0]       out_divergence,
  output logic [pbcu_pkg::CNT_W-1:0]       out_symbol_rank,
  output logic [pbcu_pkg::CNT_W-1:0]       out_row_number,
  output logic                             out_is_common,
  output logic                             out_bad,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pbcu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pbcu_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pbcu_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  pbcu_pkg::pbcu_item_t       in_item;
  pbcu_pkg::pbcu_item_t       s1_item;
  logic                       s1_valid;
  logic                       s1_take;
  logic                       has_result;
  logic                       out_space;
  pbcu_pkg::pbcu_result_t     core_res;
  pbcu_pkg::pbcu_result_t     out_res;
  logic [pbcu_pkg::CNT_W-1:0] min_count;
  logic                       out_fields_zero;
  logic                       out_counts_set;

  assign in_item = '{req_type:     in_req_type,
                     column:       in_column,
                     symbol_total: in_symbol_total,
                     symbol:       in_symbol,
                     sym_count:    in_sym_count,
                     hap_id:       in_hap_id,
                     row_div:      in_row_div};

  // Beats without a result always move on; row beats need output room
  assign s1_take = s1_valid && (!has_result || out_space);

  pbcu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_count (min_count)
  );

  pbcu_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  pbcu_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (s1_item),
    .take       (s1_take),
    .min_count  (min_count),
    .has_result (has_result),
    .result     (core_res)
  );

  pbcu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_take && has_result),
    .res_in    (core_res),
    .space     (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  assign out_dest_index  = out_res.dest_index;
  assign out_hap_id      = out_res.hap_id;
  assign out_divergence  = out_res.divergence;
  assign out_symbol_rank = out_res.symbol_rank;
  assign out_row_number  = out_res.row_number;
  assign out_is_common   = out_res.is_common;
  assign out_bad         = out_res.bad;

  // Checks
  assign out_fields_zero = (out_dest_index == '0) && (out_divergence == '0) &&
                           (out_symbol_rank == '0) && !out_is_common;
  assign out_counts_set  = (out_symbol_rank != '0) && (out_row_number != '0);

  `PBCU_ASSERT_IMP(a_bad_zeroes, out_valid && out_bad, out_fields_zero)
  `PBCU_ASSERT_IMP(a_good_rank, out_valid && !out_bad, out_counts_set)
  `PBCU_ASSERT_NXT(a_held_stays, s1_valid && !s1_take, s1_valid)
  `PBCU_ASSERT_IMP(a_empty_ready, !s1_valid, in_ready)

endmodule
